// File: hdl/gpc_pkg.sv
package gpc_pkg;

    // Only the low RATE_BITS bits of each rate take part.
    localparam int RATE_BITS = 32;
    localparam logic [31:0] RATE_MASK = (RATE_BITS >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << RATE_BITS) - 64'd1);

    localparam int N_COEF = 20;
    localparam logic [63:0] DEC_ONE = 64'd1000000000000000000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_SUM = 2'd1,
        ST_ZERO_DEN = 2'd2,
        ST_SAT      = 2'd3
    } status_t;

    // Polynomial coefficient k in Q.50, rounded half up, sign applied after.
    function automatic logic signed [63:0] coef_q50(input int k);
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] r;
        logic        neg;
        case (k)
            0:  m = 64'd1998;
            1:  m = 64'd886226910608228700;
            2:  m = 64'd39635;
            3:  m = 64'd232020829650390340;
            4:  m = 64'd312583;
            5:  m = 64'd127032886325276930;
            6:  m = 64'd3393341;
            7:  m = 64'd100233344365144250;
            8:  m = 64'd29169001;
            9:  m = 64'd103118563550561320;
            10: m = 64'd136618938;
            11: m = 64'd1148563634025252000;
            12: m = 64'd360825259;
            13: m = 64'd3962798000925986700;
            14: m = 64'd539519540;
            15: m = 64'd8220541245507180000;
            16: m = 64'd420568469;
            17: m = 64'd8702399491304316000;
            18: m = 64'd132605926;
            19: m = 64'd3850157790038759000;
            default: m = 64'd0;
        endcase
        neg = (k == 6) || (k == 9) || (k == 13) || (k == 17);
        q = m / DEC_ONE;
        r = m % DEC_ONE;
        for (int i = 0; i < 50; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= DEC_ONE) begin
                r = r - DEC_ONE;
                q = q | 64'd1;
            end
        end
        if ((r << 1) >= DEC_ONE) begin
            q = q + 64'd1;
        end
        return neg ? $signed(-q) : $signed(q);
    endfunction

    // Asymmetry divider stage: one quotient bit per lane.
    typedef struct packed {
        logic [32:0]        s1;
        logic [32:0]        s2;
        logic [32:0]        r1;
        logic [32:0]        r2;
        logic [30:0]        q1;
        logic [30:0]        q2;
        logic               n1;
        logic               n2;
        logic               zs;
        logic signed [31:0] ang1;
        logic signed [31:0] ang2;
    } asym_t;

    // Horner accumulator stage.
    typedef struct packed {
        logic signed [63:0] acc1;
        logic signed [63:0] acc2;
        logic [30:0]        ux1;
        logic [30:0]        ux2;
        logic               xn1;
        logic               xn2;
        logic               zs;
        logic signed [31:0] ang1;
        logic signed [31:0] ang2;
    } hor_t;

    // Horner partial products.
    typedef struct packed {
        logic [54:0]        ph1;
        logic [54:0]        ph2;
        logic [62:0]        pl1;
        logic [62:0]        pl2;
        logic               pn1;
        logic               pn2;
        logic [30:0]        ux1;
        logic [30:0]        ux2;
        logic               xn1;
        logic               xn2;
        logic               zs;
        logic signed [31:0] ang1;
        logic signed [31:0] ang2;
    } mul_t;

    typedef struct packed {
        logic signed [31:0] e1;
        logic signed [31:0] e2;
        logic               zs;
        logic signed [31:0] ang1;
        logic signed [31:0] ang2;
    } rnd_t;

    typedef struct packed {
        logic signed [63:0] p2;
        logic signed [63:0] p1;
        logic signed [32:0] den;
        logic               zs;
    } prd_t;

    typedef struct packed {
        logic [62:0] nmag;
        logic [32:0] dmag;
        logic        neg;
        status_t     code;
    } num_t;

    // Centre divider stage.
    typedef struct packed {
        logic [62:0] r;
        logic [31:0] q;
        logic [32:0] dmag;
        logic        neg;
        logic        big;
        status_t     code;
    } div_t;

endpackage

// File: hdl/gauss_peak_center_from_asymmetry.sv
// Gaussian peak centre from two detector asymmetries. Each beat carries two
// scan angles (signed Q16.16 degrees) with a pair of count rates each. For
// both angles the asymmetry (a-b)/(a+b) is formed in Q2.30, mapped through a
// degree-19 inverse-erf polynomial into Q6.26, and the centre
// (second_angle*E1 - first_angle*E2) / (E1 - E2) is returned in Q16.16.
// status: 0 ok, 1 a rate sum is zero, 2 E1 equals E2 (centre reads 0 for
// both), 3 centre clamped to the 32-bit range. The datapath is a fixed
// 107-stage pipeline: 1 prep, 31 asymmetry divider bits, 19 Horner steps of
// two stages each (multiply, then add), 1 rounding, 1 product, 1 numerator,
// 1 range check, 32 centre divider bits and the output register. One beat
// is taken every cycle while the pipe is not stalled. A stall on a held
// result beat freezes the whole pipe and is passed straight back to item_stall.
module gauss_peak_center_from_asymmetry (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] first_angle,
    input  logic [31:0]        first_rate_a,
    input  logic [31:0]        first_rate_b,
    input  logic signed [31:0] second_angle,
    input  logic [31:0]        second_rate_a,
    input  logic [31:0]        second_rate_b,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] center_angle,
    output gpc_pkg::status_t   status
);
    import gpc_pkg::*;

    localparam int N_ASYM  = 31;
    localparam int N_STEP  = N_COEF - 1;
    localparam int N_DIV   = 32;
    localparam logic signed [63:0] C_TOP = coef_q50(N_COEF - 1);

    logic adv;

    // whole pipe moves unless the result beat is held
    assign adv        = !(result_valid && result_stall);
    assign item_stall = !adv;

    // ---------------------------------------------------------------
    // prep: masked rates, sums, magnitudes of difference
    // ---------------------------------------------------------------
    asym_t pre_next, pre_reg;
    logic  pre_v_reg;
    logic [31:0] ra1, rb1, ra2, rb2;

    always_comb
    begin
        ra1 = first_rate_a & RATE_MASK;
        rb1 = first_rate_b & RATE_MASK;
        ra2 = second_rate_a & RATE_MASK;
        rb2 = second_rate_b & RATE_MASK;
        pre_next.s1   = {1'b0, ra1} + {1'b0, rb1};
        pre_next.s2   = {1'b0, ra2} + {1'b0, rb2};
        pre_next.r1   = {1'b0, (ra1 >= rb1) ? (ra1 - rb1) : (rb1 - ra1)};
        pre_next.r2   = {1'b0, (ra2 >= rb2) ? (ra2 - rb2) : (rb2 - ra2)};
        pre_next.q1   = '0;
        pre_next.q2   = '0;
        pre_next.n1   = ra1 < rb1;
        pre_next.n2   = ra2 < rb2;
        pre_next.zs   = (pre_next.s1 == 33'd0) || (pre_next.s2 == 33'd0);
        pre_next.ang1 = first_angle;
        pre_next.ang2 = second_angle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            pre_v_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre_reg <= pre_next;
        end
    end

    // ---------------------------------------------------------------
    // asymmetry: restoring division, one bit per stage
    // ---------------------------------------------------------------
    asym_t a_reg   [0:N_ASYM-1];
    logic  a_v_reg [0:N_ASYM-1];

    for (genvar j = 0; j < N_ASYM; j++)
    begin : g_asym
        asym_t       src;
        logic        src_v;
        asym_t       a_next;
        logic [33:0] rr1, rr2, df1, df2;
        logic        ge1, ge2;

        if (j == 0)
        begin : g_first
            assign src   = pre_reg;
            assign src_v = pre_v_reg;
        end
        else
        begin : g_rest
            assign src   = a_reg[j-1];
            assign src_v = a_v_reg[j-1];
        end

        always_comb
        begin
            rr1 = (j == 0) ? {1'b0, src.r1} : {src.r1, 1'b0};
            rr2 = (j == 0) ? {1'b0, src.r2} : {src.r2, 1'b0};
            ge1 = rr1 >= {1'b0, src.s1};
            ge2 = rr2 >= {1'b0, src.s2};
            df1 = rr1 - {1'b0, src.s1};
            df2 = rr2 - {1'b0, src.s2};
            a_next    = src;
            a_next.r1 = ge1 ? df1[32:0] : rr1[32:0];
            a_next.r2 = ge2 ? df2[32:0] : rr2[32:0];
            a_next.q1 = {src.q1[29:0], ge1};
            a_next.q2 = {src.q2[29:0], ge2};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_v_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                a_v_reg[j] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_reg[j] <= a_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // inverse-erf polynomial, Horner in Q.50, both lanes side by side
    // ---------------------------------------------------------------
    hor_t h_src0;
    hor_t h_reg   [1:N_STEP];
    logic h_v_reg [1:N_STEP];
    mul_t m_reg   [0:N_STEP-1];
    logic m_v_reg [0:N_STEP-1];

    always_comb
    begin
        h_src0.acc1 = C_TOP;
        h_src0.acc2 = C_TOP;
        h_src0.ux1  = a_reg[N_ASYM-1].q1;
        h_src0.ux2  = a_reg[N_ASYM-1].q2;
        h_src0.xn1  = a_reg[N_ASYM-1].n1;
        h_src0.xn2  = a_reg[N_ASYM-1].n2;
        h_src0.zs   = a_reg[N_ASYM-1].zs;
        h_src0.ang1 = a_reg[N_ASYM-1].ang1;
        h_src0.ang2 = a_reg[N_ASYM-1].ang2;
    end

    for (genvar i = 0; i < N_STEP; i++)
    begin : g_horner
        localparam logic signed [63:0] C = coef_q50(N_STEP - 1 - i);
        hor_t        hs;
        logic        hs_v;
        mul_t        m_next;
        hor_t        h_next;
        logic [63:0] ua1, ua2, p1, p2, sp1, sp2;

        if (i == 0)
        begin : g_first
            assign hs   = h_src0;
            assign hs_v = a_v_reg[N_ASYM-1];
        end
        else
        begin : g_rest
            assign hs   = h_reg[i];
            assign hs_v = h_v_reg[i];
        end

        // multiply: |acc| split at bit 32, each half times |x|
        always_comb
        begin
            ua1 = hs.acc1[63] ? 64'(-hs.acc1) : 64'(hs.acc1);
            ua2 = hs.acc2[63] ? 64'(-hs.acc2) : 64'(hs.acc2);
            m_next.ph1  = ua1[55:32] * hs.ux1;
            m_next.ph2  = ua2[55:32] * hs.ux2;
            m_next.pl1  = ua1[31:0] * hs.ux1;
            m_next.pl2  = ua2[31:0] * hs.ux2;
            m_next.pn1  = hs.acc1[63] ^ hs.xn1;
            m_next.pn2  = hs.acc2[63] ^ hs.xn2;
            m_next.ux1  = hs.ux1;
            m_next.ux2  = hs.ux2;
            m_next.xn1  = hs.xn1;
            m_next.xn2  = hs.xn2;
            m_next.zs   = hs.zs;
            m_next.ang1 = hs.ang1;
            m_next.ang2 = hs.ang2;
        end

        // add: product >> 30, sign, next coefficient
        always_comb
        begin
            p1  = {7'b0, m_reg[i].ph1, 2'b0} + {31'b0, m_reg[i].pl1[62:30]};
            p2  = {7'b0, m_reg[i].ph2, 2'b0} + {31'b0, m_reg[i].pl2[62:30]};
            sp1 = m_reg[i].pn1 ? -p1 : p1;
            sp2 = m_reg[i].pn2 ? -p2 : p2;
            h_next.acc1 = $signed(sp1) + C;
            h_next.acc2 = $signed(sp2) + C;
            h_next.ux1  = m_reg[i].ux1;
            h_next.ux2  = m_reg[i].ux2;
            h_next.xn1  = m_reg[i].xn1;
            h_next.xn2  = m_reg[i].xn2;
            h_next.zs   = m_reg[i].zs;
            h_next.ang1 = m_reg[i].ang1;
            h_next.ang2 = m_reg[i].ang2;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                m_v_reg[i]   <= 1'b0;
                h_v_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                m_v_reg[i]   <= hs_v;
                h_v_reg[i+1] <= m_v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m_reg[i]   <= m_next;
                h_reg[i+1] <= h_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // round to Q6.26, products, numerator, range check
    // ---------------------------------------------------------------
    rnd_t rnd_next, rnd_reg;
    prd_t prd_next, prd_reg;
    num_t num_next, num_reg;
    div_t chk_next, chk_reg;
    logic rnd_v_reg, prd_v_reg, num_v_reg, chk_v_reg;
    logic [63:0] ur1, ur2, rs1, rs2;
    logic [31:0] em1, em2;
    logic signed [63:0] num;
    logic [63:0] nabs;
    logic [32:0] dabs;

    always_comb
    begin
        ur1 = h_reg[N_STEP].acc1[63] ? 64'(-h_reg[N_STEP].acc1) : 64'(h_reg[N_STEP].acc1);
        ur2 = h_reg[N_STEP].acc2[63] ? 64'(-h_reg[N_STEP].acc2) : 64'(h_reg[N_STEP].acc2);
        rs1 = ur1 + 64'd8388608;
        rs2 = ur2 + 64'd8388608;
        em1 = rs1[55:24];
        em2 = rs2[55:24];
        rnd_next.e1   = h_reg[N_STEP].acc1[63] ? $signed(-em1) : $signed(em1);
        rnd_next.e2   = h_reg[N_STEP].acc2[63] ? $signed(-em2) : $signed(em2);
        rnd_next.zs   = h_reg[N_STEP].zs;
        rnd_next.ang1 = h_reg[N_STEP].ang1;
        rnd_next.ang2 = h_reg[N_STEP].ang2;
    end

    always_comb
    begin
        prd_next.p2  = rnd_reg.ang2 * rnd_reg.e1;
        prd_next.p1  = rnd_reg.ang1 * rnd_reg.e2;
        prd_next.den = $signed({rnd_reg.e1[31], rnd_reg.e1})
                     - $signed({rnd_reg.e2[31], rnd_reg.e2});
        prd_next.zs  = rnd_reg.zs;
    end

    always_comb
    begin
        num  = prd_reg.p2 - prd_reg.p1;
        nabs = num[63] ? 64'(-num) : 64'(num);
        dabs = prd_reg.den[32] ? 33'(-prd_reg.den) : 33'(prd_reg.den);
        num_next.nmag = nabs[62:0];
        num_next.dmag = dabs;
        num_next.neg  = num[63] ^ prd_reg.den[32];
        if (prd_reg.zs)
        begin
            num_next.code = ST_ZERO_SUM;
        end
        else if (prd_reg.den == 33'sd0)
        begin
            num_next.code = ST_ZERO_DEN;
        end
        else
        begin
            num_next.code = ST_OK;
        end
    end

    // quotient of 2^32 or more saturates either way
    always_comb
    begin
        chk_next.r    = num_reg.nmag;
        chk_next.q    = '0;
        chk_next.dmag = num_reg.dmag;
        chk_next.neg  = num_reg.neg;
        chk_next.big  = {2'b0, num_reg.nmag} >= {num_reg.dmag, 32'b0};
        chk_next.code = num_reg.code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_v_reg <= 1'b0;
            prd_v_reg <= 1'b0;
            num_v_reg <= 1'b0;
            chk_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            rnd_v_reg <= h_v_reg[N_STEP];
            prd_v_reg <= rnd_v_reg;
            num_v_reg <= prd_v_reg;
            chk_v_reg <= num_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rnd_reg <= rnd_next;
            prd_reg <= prd_next;
            num_reg <= num_next;
            chk_reg <= chk_next;
        end
    end

    // ---------------------------------------------------------------
    // centre: 32-bit quotient, one bit per stage, MSB first
    // ---------------------------------------------------------------
    div_t d_reg   [0:N_DIV-1];
    logic d_v_reg [0:N_DIV-1];

    for (genvar k = 0; k < N_DIV; k++)
    begin : g_div
        div_t        src;
        logic        src_v;
        div_t        d_next;
        logic [64:0] t;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign src   = chk_reg;
            assign src_v = chk_v_reg;
        end
        else
        begin : g_rest
            assign src   = d_reg[k-1];
            assign src_v = d_v_reg[k-1];
        end

        always_comb
        begin
            t      = {32'b0, src.dmag} << (N_DIV - 1 - k);
            ge     = {2'b0, src.r} >= t;
            d_next   = src;
            d_next.r = ge ? (src.r - t[62:0]) : src.r;
            d_next.q = {src.q[30:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                d_v_reg[k] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_reg[k] <= d_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // output register: sign, clamp, status
    // ---------------------------------------------------------------
    div_t        fin;
    logic        out_v_reg;
    logic signed [31:0] center_next, center_reg;
    status_t     status_next, status_reg;

    assign fin = d_reg[N_DIV-1];

    always_comb
    begin
        case (fin.code)
            ST_ZERO_SUM:
            begin
                center_next = '0;
                status_next = ST_ZERO_SUM;
            end
            ST_ZERO_DEN:
            begin
                center_next = '0;
                status_next = ST_ZERO_DEN;
            end
            default:
            begin
                if (fin.big || (!fin.neg && fin.q[31])
                    || (fin.neg && fin.q[31] && (fin.q[30:0] != 31'd0)))
                begin
                    center_next = fin.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    status_next = ST_SAT;
                end
                else
                begin
                    center_next = fin.neg ? $signed(-fin.q) : $signed(fin.q);
                    status_next = ST_OK;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= d_v_reg[N_DIV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            center_reg <= center_next;
            status_reg <= status_next;
        end
    end

    assign result_valid = out_v_reg;
    assign center_angle = center_reg;
    assign status       = status_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_ZERO_SUM || status == ST_ZERO_DEN)
        |-> center_angle == 32'sd0)
        else $error("error beat with nonzero centre");

    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_SAT
        |-> center_angle == 32'sh7FFF_FFFF || center_angle == 32'sh8000_0000)
        else $error("saturated beat not at a limit");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled with no held result");

endmodule
